>>> hdl/umpq_pkg.sv
package umpq_pkg;

    // Default sizing
    localparam int UMPQ_CAPACITY  = 64;
    localparam int UMPQ_ITEM_BITS = 16;
    localparam int UMPQ_PRIO_BITS = 32;

    // Operation codes on i_func (code 3 is unused and does nothing)
    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_DEQUEUE = 2'd1,
        FUNC_UPDATE  = 2'd2
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_SHIFT,
        S_TAIL,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // capture operands, restart scan
        logic scan_issue;   // read next entry for the scan
        logic scan_cmp;     // evaluate the returned entry
        logic is_deq;       // scan looks for the minimum, not for the item
        logic prep;         // point the sweep just past the hit
        logic shift_issue;  // read next entry for the shift
        logic shift_wr;     // write returned entry one slot lower
        logic tail_wr;      // write operand pair at the tail
        logic tail_append;  // tail write grows the table
        logic cnt_dec;      // one entry removed
        logic take_out;     // latch the removed item
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic found;        // item hit during scan
        logic sweep_end;    // all entries read and the last read consumed
        logic cnt_zero;     // table empty
        logic full;         // table at capacity
    } t_sts;

endpackage

>>> hdl/umpq_ctrl.sv
module umpq_ctrl
    import umpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_func,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_done,
    output logic [1:0] o_status
);

    t_state  r_state, n_state;
    t_func   r_func, n_func;
    t_status r_status, n_status;

    // State and operand registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_func   <= FUNC_INSERT;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_func   <= n_func;
            r_status <= n_status;
        end
    end

    // Next state
    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func   = t_func'(i_func);
                    n_status = ST_OK;
                    case (i_func)
                        FUNC_INSERT, FUNC_UPDATE: n_state = S_SCAN;
                        FUNC_DEQUEUE: begin
                            if (i_sts.cnt_zero) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_func != FUNC_DEQUEUE && i_sts.found) begin
                    n_state = S_PREP;
                end else if (i_sts.sweep_end) begin
                    case (r_func)
                        FUNC_DEQUEUE: n_state = S_PREP;
                        FUNC_INSERT: begin
                            if (i_sts.full) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_TAIL;
                            end
                        end
                        default: begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_PREP:  n_state = S_SHIFT;
            S_SHIFT: begin
                if (i_sts.sweep_end) begin
                    n_state = (r_func == FUNC_DEQUEUE) ? S_DONE : S_TAIL;
                end
            end
            S_TAIL:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.is_deq = (r_func == FUNC_DEQUEUE);
        case (r_state)
            S_IDLE:  o_cmd.load = i_start;
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                o_cmd.scan_cmp   = 1'b1;
            end
            S_PREP: begin
                o_cmd.prep     = 1'b1;
                o_cmd.take_out = (r_func == FUNC_DEQUEUE);
            end
            S_SHIFT: begin
                o_cmd.shift_issue = 1'b1;
                o_cmd.shift_wr    = 1'b1;
                o_cmd.cnt_dec     = i_sts.sweep_end && (r_func == FUNC_DEQUEUE);
            end
            S_TAIL: begin
                o_cmd.tail_wr     = 1'b1;
                o_cmd.tail_append = !i_sts.found;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_status = r_status;

endmodule

>>> hdl/umpq_dpath.sv
module umpq_dpath
    import umpq_pkg::*;
#(
    parameter int CAPACITY  = UMPQ_CAPACITY,
    parameter int ITEM_BITS = UMPQ_ITEM_BITS,
    parameter int PRIO_BITS = UMPQ_PRIO_BITS,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [ITEM_BITS-1:0] i_item_id,
    input  logic [PRIO_BITS-1:0] i_prio,
    output t_sts                 o_sts,
    output logic [ITEM_BITS-1:0] o_out_item,
    output logic [CW-1:0]        o_count
);

    localparam int DW = ITEM_BITS + PRIO_BITS;

    // Entry table: {item, priority}
    logic [DW-1:0] mem [CAPACITY];

    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_pos;
    logic                 r_found;
    logic                 r_rd_vld;
    logic [AW-1:0]        r_rd_tag;
    logic [DW-1:0]        r_rd_data;
    logic [ITEM_BITS-1:0] r_item;
    logic [PRIO_BITS-1:0] r_prio;
    logic [PRIO_BITS-1:0] r_best_prio;
    logic [ITEM_BITS-1:0] r_best_item;
    logic [ITEM_BITS-1:0] r_out_item;

    logic                 idx_lt_cnt;
    logic                 issue;
    logic [ITEM_BITS-1:0] rd_item;
    logic [PRIO_BITS-1:0] rd_prio;
    logic                 cmp_vld;
    logic                 new_min;
    logic [CW-1:0]        cnt_m1;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [DW-1:0]        wr_data;

    assign idx_lt_cnt = (r_idx < r_count);
    assign issue      = (i_cmd.scan_issue || i_cmd.shift_issue) && idx_lt_cnt;
    assign rd_item    = r_rd_data[DW-1:PRIO_BITS];
    assign rd_prio    = r_rd_data[PRIO_BITS-1:0];
    assign cmp_vld    = i_cmd.scan_cmp && r_rd_vld;
    // first entry seeds the minimum; ties keep the earlier entry
    assign new_min    = (r_rd_tag == '0) || ($signed(rd_prio) < $signed(r_best_prio));
    assign cnt_m1     = r_count - CW'(1);

    // Write port: shift moves an entry down one slot, tail writes the operands
    always_comb begin
        wr_en   = (i_cmd.shift_wr && r_rd_vld) || i_cmd.tail_wr;
        wr_data = {r_item, r_prio};
        wr_addr = i_cmd.tail_append ? r_count[AW-1:0] : cnt_m1[AW-1:0];
        if (i_cmd.shift_wr) begin
            wr_data = r_rd_data;
            wr_addr = r_rd_tag - AW'(1);
        end
    end

    // Table memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= mem[r_idx[AW-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.prep) begin
                r_idx <= CW'(r_pos) + CW'(1);
            end else if (issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (cmp_vld && !i_cmd.is_deq && !r_found && rd_item == r_item) begin
                r_found <= 1'b1;
            end
            if (i_cmd.tail_wr && i_cmd.tail_append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= cnt_m1;
            end
        end
    end

    // Operand, scan and result payload
    always_ff @(posedge i_clk) begin
        r_rd_tag <= r_idx[AW-1:0];
        if (i_cmd.load) begin
            r_item     <= i_item_id;
            r_prio     <= i_prio;
            r_out_item <= '0;
        end
        if (i_cmd.take_out) begin
            r_out_item <= r_best_item;
        end
        if (cmp_vld) begin
            if (i_cmd.is_deq) begin
                if (new_min) begin
                    r_best_prio <= rd_prio;
                    r_best_item <= rd_item;
                    r_pos       <= r_rd_tag;
                end
            end else if (!r_found && rd_item == r_item) begin
                r_pos <= r_rd_tag;
            end
        end
    end

    assign o_sts.found     = r_found;
    assign o_sts.sweep_end = !idx_lt_cnt && !r_rd_vld;
    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.full      = (r_count == CW'(CAPACITY));
    assign o_out_item      = r_out_item;
    assign o_count         = r_count;

endmodule

>>> hdl/unsorted_min_priority_queue_unit.sv
// Channel | Ports                                       | Handshake
// --------+---------------------------------------------+----------------------------
// command | i_func, i_item_id, i_prio                   | i_start high, o_busy low
// result  | o_out_item, o_status, o_count, o_is_empty   | o_done high for one cycle
//
// One operation at a time; o_busy stays high from the accepting edge until after o_done.
// An append, a refused insert or update, an insert/update of a held item and a dequeue all scan
// the table; the last two then shift the later entries down one slot. An empty dequeue or the
// unused code goes straight to the result. All of it runs through the single table read port,
// one entry a cycle.
// Reset (i_rst_n low, synchronous) empties the table, entries are not cleared; no stalls.
module unsorted_min_priority_queue_unit
    import umpq_pkg::*;
#(
    parameter int CAPACITY  = UMPQ_CAPACITY,
    parameter int ITEM_BITS = UMPQ_ITEM_BITS,
    parameter int PRIO_BITS = UMPQ_PRIO_BITS,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_func,
    input  logic [ITEM_BITS-1:0] i_item_id,
    input  logic [PRIO_BITS-1:0] i_prio,
    output logic                 o_done,
    output logic [ITEM_BITS-1:0] o_out_item,
    output logic [1:0]           o_status,
    output logic [CW-1:0]        o_count,
    output logic                 o_is_empty
);

    t_cmd cmd;
    t_sts sts;
    logic busy;
    logic start_acc;

    assign start_acc = i_start && !busy;

    umpq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start_acc),
        .i_func   (i_func),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_status (o_status)
    );

    umpq_dpath #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (ITEM_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item_id  (i_item_id),
        .i_prio     (i_prio),
        .o_sts      (sts),
        .o_out_item (o_out_item),
        .o_count    (o_count)
    );

    assign o_busy     = busy;
    assign o_is_empty = (o_count == '0);

endmodule

>>> hdl/umpq_chk.sv
module umpq_chk
    import umpq_pkg::*;
#(
    parameter int CAPACITY  = UMPQ_CAPACITY,
    parameter int ITEM_BITS = UMPQ_ITEM_BITS,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic                 o_done,
    input logic [ITEM_BITS-1:0] o_out_item,
    input logic [1:0]           o_status,
    input logic [CW-1:0]        o_count,
    input logic                 o_is_empty
);

    // An accepted command makes the unit busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not raise busy");

    // A result beat only comes out of an operation in flight, and ends it
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_busy ##1 !o_busy))
        else $error("result beat outside an operation");

    // Fill level never exceeds capacity and the empty flag tracks it
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_count <= CW'(CAPACITY)) && (o_is_empty == (o_count == '0)))
        else $error("count out of range or empty flag wrong");

    // Dequeue on empty reports an empty table and no item
    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |-> (o_out_item == '0 && o_is_empty))
        else $error("bad empty dequeue result");

    // Count holds while the unit is idle, so it only changes within an operation
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !$past(o_busy)) |-> $stable(o_count))
        else $error("count changed while idle");

endmodule

bind unsorted_min_priority_queue_unit umpq_chk #(
    .CAPACITY  (CAPACITY),
    .ITEM_BITS (ITEM_BITS)
) u_umpq_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .o_done     (o_done),
    .o_out_item (o_out_item),
    .o_status   (o_status),
    .o_count    (o_count),
    .o_is_empty (o_is_empty)
);

>>> tb/unsorted_min_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module unsorted_min_priority_queue_unit_tb;
    import umpq_pkg::*;

    localparam int          SLOTS       = UMPQ_CAPACITY;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          STALL_LIMIT = 4000;
    localparam int          DRAIN_WAIT  = 200;

    // One expected result beat
    typedef struct {
        logic [15:0] item;
        t_status     status;
        logic [6:0]  count;
        logic        is_empty;
    } pq_result_t;

    // Shadow copy of the table, plus the results it implies
    class queue_scoreboard;
        logic [15:0]        held_item [SLOTS];
        logic signed [31:0] held_prio [SLOTS];
        int                 held_count;
        pq_result_t         result_q [$];
        int                 errors;
        int                 ops;
        int                 beats;
        int                 peak;
        int                 status_seen [4];

        function new();
            held_count = 0;
            errors     = 0;
            ops        = 0;
            beats      = 0;
            peak       = 0;
            foreach (status_seen[s]) status_seen[s] = 0;
        endfunction

        // Apply one accepted command beat and queue its result
        function void note_op(logic [1:0] func, logic [15:0] id, logic signed [31:0] p);
            pq_result_t  r;
            int          pos;
            logic [15:0] moved;

            r.item   = '0;
            r.status = ST_OK;
            pos      = -1;
            case (func)
                FUNC_INSERT, FUNC_UPDATE: begin
                    for (int i = 0; i < held_count; i++) begin
                        if (pos < 0 && held_item[i] == id) pos = i;
                    end
                    if (pos >= 0) begin
                        // new priority, entry moves to the tail
                        moved = held_item[pos];
                        for (int j = pos; j + 1 < held_count; j++) begin
                            held_item[j] = held_item[j + 1];
                            held_prio[j] = held_prio[j + 1];
                        end
                        held_item[held_count - 1] = moved;
                        held_prio[held_count - 1] = p;
                    end else if (func == FUNC_UPDATE) begin
                        r.status = ST_NOT_FOUND;
                    end else if (held_count == SLOTS) begin
                        r.status = ST_FULL;
                    end else begin
                        held_item[held_count] = id;
                        held_prio[held_count] = p;
                        held_count++;
                    end
                end
                FUNC_DEQUEUE: begin
                    if (held_count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        // strict compare keeps the earliest of equal priorities
                        pos = 0;
                        for (int i = 1; i < held_count; i++) begin
                            if (held_prio[i] < held_prio[pos]) pos = i;
                        end
                        r.item = held_item[pos];
                        for (int i = pos + 1; i < held_count; i++) begin
                            held_item[i - 1] = held_item[i];
                            held_prio[i - 1] = held_prio[i];
                        end
                        held_count--;
                    end
                end
                default: ;
            endcase
            r.count    = 7'(held_count);
            r.is_empty = (held_count == 0);
            result_q.push_back(r);
            ops++;
            status_seen[r.status]++;
            if (held_count > peak) peak = held_count;
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_result(logic [15:0] item, logic [1:0] status,
                                   logic [6:0] count, logic is_empty);
            pq_result_t want;

            if (result_q.size() == 0) begin
                $display("%0t: result beat with no command outstanding", $time);
                errors++;
                return;
            end
            want = result_q.pop_front();
            beats++;
            if (item !== want.item) begin
                $display("%0t: out_item expected %h got %h", $time, want.item, item);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, status);
                errors++;
            end
            if (count !== want.count) begin
                $display("%0t: count expected %0d got %0d", $time, want.count, count);
                errors++;
            end
            if (is_empty !== want.is_empty) begin
                $display("%0t: is_empty expected %b got %b", $time, want.is_empty, is_empty);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_start   = 1'b0;
    logic [1:0]  i_func    = '0;
    logic [15:0] i_item_id = '0;
    logic [31:0] i_prio    = '0;
    logic        o_busy;
    logic        o_done;
    logic [15:0] o_out_item;
    logic [1:0]  o_status;
    logic [6:0]  o_count;
    logic        o_is_empty;

    queue_scoreboard sb = new();
    int              idle_pct = 0;
    int              quiet_cycles = 0;

    unsorted_min_priority_queue_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_func     (i_func),
        .i_item_id  (i_item_id),
        .i_prio     (i_prio),
        .o_done     (o_done),
        .o_out_item (o_out_item),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result beats cannot be held off, check each one as it appears
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            sb.check_result(o_out_item, o_status, o_count, o_is_empty);
    end

    // Watchdog: too long without a command or result beat
    always @(posedge i_clk) begin
        if ((i_start && o_busy === 1'b0) || o_done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Priority mix: extremes, a narrow band for ties, full random
    function automatic logic [31:0] rand_prio();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    // Present one command beat, with optional idle cycles first
    task automatic issue_op(input logic [1:0] func, input logic [15:0] id,
                            input logic [31:0] p);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_func    <= func;
        i_item_id <= id;
        i_prio    <= p;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        sb.note_op(func, id, p);
    endtask

    initial begin
        int          phase_idle [4];
        int          fill_len;
        logic [15:0] base;
        logic [15:0] id;
        logic [1:0]  func;

        phase_idle = '{0, 75, 24, 0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty cases, extremes, ties, insert-as-update
        issue_op(FUNC_DEQUEUE, 16'hffff, 32'h7fff_ffff);
        issue_op(FUNC_UPDATE,  16'h0000, 32'h0000_0000);
        issue_op(FUNC_UNUSED,  16'hffff, 32'hffff_ffff);
        issue_op(FUNC_INSERT,  16'h0000, 32'h7fff_ffff);
        issue_op(FUNC_INSERT,  16'hffff, 32'h8000_0000);
        issue_op(FUNC_INSERT,  16'h0005, 32'h0000_0000);
        issue_op(FUNC_INSERT,  16'h0007, 32'h0000_0000);
        issue_op(FUNC_INSERT,  16'h0000, 32'hffff_ffff);
        issue_op(FUNC_UPDATE,  16'hffff, 32'h7fff_ffff);
        issue_op(FUNC_UPDATE,  16'h1234, 32'h0000_0001);
        issue_op(FUNC_UNUSED,  16'h5a5a, 32'ha5a5_a5a5);
        issue_op(FUNC_DEQUEUE, 16'h0000, 32'h0000_0000);
        issue_op(FUNC_DEQUEUE, 16'hffff, 32'hffff_ffff);
        issue_op(FUNC_UPDATE,  16'h0007, 32'h8000_0001);
        issue_op(FUNC_INSERT,  16'haaaa, 32'h8000_0000);
        issue_op(FUNC_INSERT,  16'h5555, 32'h5555_5555);
        issue_op(FUNC_DEQUEUE, 16'h0000, 32'h0000_0000);
        issue_op(FUNC_DEQUEUE, 16'h0000, 32'h0000_0000);
        issue_op(FUNC_DEQUEUE, 16'h0000, 32'h0000_0000);
        issue_op(FUNC_DEQUEUE, 16'h0000, 32'h0000_0000);
        issue_op(FUNC_DEQUEUE, 16'h0000, 32'h0000_0000);

        // Random phases: fill (past full on even phases), mixed traffic, drain
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = phase_idle[ph];
            base     = 16'($urandom);
            fill_len = (ph % 2 == 0) ? 80 : $urandom_range(20, 60);
            for (int k = 0; k < fill_len; k++) begin
                if (k > 0 && $urandom_range(0, 9) == 0)
                    id = base + 16'($urandom_range(0, k - 1));
                else
                    id = base + 16'(k);
                issue_op(FUNC_INSERT, id, rand_prio());
            end
            for (int k = 0; k < 70; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: func = FUNC_INSERT;
                    4, 5:       func = FUNC_UPDATE;
                    6, 7, 8:    func = FUNC_DEQUEUE;
                    default:    func = FUNC_UNUSED;
                endcase
                if ($urandom_range(0, 1) == 1)
                    id = base + 16'($urandom_range(0, 90));
                else
                    id = 16'($urandom);
                issue_op(func, id, rand_prio());
            end
            while (sb.held_count > 0)
                issue_op(FUNC_DEQUEUE, 16'($urandom), $urandom);
            issue_op(FUNC_DEQUEUE, 16'($urandom), $urandom);
        end

        i_start <= 1'b0;
        while (sb.result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d result beats for %0d commands; peak occupancy %0d of %0d",
                 sb.beats, sb.ops, sb.peak, SLOTS);
        $display("Status mix: ok %0d, empty dequeue %0d, full insert %0d, not found %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_NOT_FOUND]);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> unsorted_min_priority_queue_unit.f
hdl/umpq_pkg.sv
hdl/umpq_ctrl.sv
hdl/umpq_dpath.sv
hdl/unsorted_min_priority_queue_unit.sv
hdl/umpq_chk.sv
tb/unsorted_min_priority_queue_unit_tb.sv
